>>> hw/rtl/ocook_pkg.sv
// ----------------------------------------------------------------------------
// Oven cook controller package
// Shared widths, default parameter values, phase, mode and register codes.
// ----------------------------------------------------------------------------
package ocook_pkg;

    // Default values for the top-level parameters.
    localparam int LED_COUNT_DEF = 8;
    localparam int TICK_BITS_DEF = 16;
    localparam int KNOB_BITS_DEF = 10;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [2:0]            t_phase;
    typedef logic [1:0]            t_mode;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Phase codes.
    localparam t_phase PH_SETUP  = 3'd0;
    localparam t_phase PH_SELECT = 3'd1;
    localparam t_phase PH_COOK   = 3'd2;
    localparam t_phase PH_RESET  = 3'd3;
    localparam t_phase PH_TIMEUP = 3'd4;

    // Cook modes.
    localparam t_mode MODE_BAKE  = 2'd0;
    localparam t_mode MODE_TOAST = 2'd1;
    localparam t_mode MODE_BROIL = 2'd2;

    // Knob adjust target.
    localparam logic TGT_TEMP = 1'b0;
    localparam logic TGT_TIME = 1'b1;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_LONG_PRESS  = 3'd0;
    localparam t_cfg_idx CFG_TICKS_SEC   = 3'd1;
    localparam t_cfg_idx CFG_BLINK_TICKS = 3'd2;
    localparam t_cfg_idx CFG_MIN_TEMP    = 3'd3;
    localparam t_cfg_idx CFG_BROIL_TEMP  = 3'd4;
    localparam t_cfg_idx CFG_BAKE_TEMP   = 3'd5;

    // Register reset values.
    localparam logic [7:0] LONG_PRESS_RST  = 8'd5;
    localparam logic [7:0] TICKS_SEC_RST   = 8'd5;
    localparam logic [7:0] BLINK_TICKS_RST = 8'd2;
    localparam logic [9:0] MIN_TEMP_RST    = 10'd300;
    localparam logic [9:0] BROIL_TEMP_RST  = 10'd500;
    localparam logic [9:0] BAKE_TEMP_RST   = 10'd350;

endpackage

>>> hw/rtl/ocook_ifs.sv
// ----------------------------------------------------------------------------
// Oven cook controller channel interfaces
// Event beat channel into the controller and result beat channel out of it.
// ----------------------------------------------------------------------------
interface ocook_in_if #(
    parameter int KNOB_BITS = ocook_pkg::KNOB_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 tick;
    logic                 knob_valid;
    logic [KNOB_BITS-1:0] knob_value;
    logic                 select_press;
    logic                 select_release;
    logic                 start_press;
    logic                 start_release;

    modport source (
        output valid, tick, knob_valid, knob_value, select_press, select_release,
               start_press, start_release,
        input  ready
    );
    modport sink (
        input  valid, tick, knob_valid, knob_value, select_press, select_release,
               start_press, start_release,
        output ready
    );
endinterface

interface ocook_out_if #(
    parameter int LED_COUNT = ocook_pkg::LED_COUNT_DEF
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           oven_state;
    logic [1:0]           cook_mode;
    logic                 adjust_target;
    logic [8:0]           set_time;
    logic [8:0]           remaining_time;
    logic [10:0]          set_temperature;
    logic [LED_COUNT-1:0] led_bar;
    logic                 heater_on;
    logic                 display_inverted;
    logic                 refresh;

    modport source (
        output valid, oven_state, cook_mode, adjust_target, set_time, remaining_time,
               set_temperature, led_bar, heater_on, display_inverted, refresh,
        input  ready
    );
    modport sink (
        input  valid, oven_state, cook_mode, adjust_target, set_time, remaining_time,
               set_temperature, led_bar, heater_on, display_inverted, refresh,
        output ready
    );
endinterface

>>> hw/rtl/oven_cook_controller_top.sv
// ----------------------------------------------------------------------------
// Oven cook controller
// Five-phase toaster-oven controller stepped by one event beat at a time.
// ----------------------------------------------------------------------------
// Each input beat carries the timebase tick, a knob reading and the button
// edges; each accepted beat produces exactly one result beat with the state
// shown to the user. The block takes one beat per clock: the whole update of
// the controller state is a single combinational pass from the state
// registers and the incoming beat into the state registers and the result
// register. A new beat is accepted whenever the result register is empty or
// its beat is being taken in the same cycle, so a result appears in the
// cycle after its beat and a stalled sink holds back the source only while
// the result register is full. There is no clearing pass after reset. The
// configuration registers must only be written while no result is waiting.
// ----------------------------------------------------------------------------
module oven_cook_controller_top #(
    parameter int LED_COUNT = ocook_pkg::LED_COUNT_DEF,
    parameter int TICK_BITS = ocook_pkg::TICK_BITS_DEF,
    parameter int KNOB_BITS = ocook_pkg::KNOB_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ocook_in_if.sink             i_in,
    ocook_out_if.source          o_out,
    input  logic                 i_cfg_we,
    input  ocook_pkg::t_cfg_idx  i_cfg_index,
    input  ocook_pkg::t_cfg_data i_cfg_data
);
    import ocook_pkg::*;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [7:0] r_cfg_long;
    logic [7:0] r_cfg_tps;
    logic [7:0] r_cfg_blink;
    logic [9:0] r_cfg_min_temp;
    logic [9:0] r_cfg_broil_temp;
    logic [9:0] r_cfg_bake_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_long       <= LONG_PRESS_RST;
            r_cfg_tps        <= TICKS_SEC_RST;
            r_cfg_blink      <= BLINK_TICKS_RST;
            r_cfg_min_temp   <= MIN_TEMP_RST;
            r_cfg_broil_temp <= BROIL_TEMP_RST;
            r_cfg_bake_temp  <= BAKE_TEMP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_PRESS:  r_cfg_long       <= i_cfg_data[7:0];
                CFG_TICKS_SEC:   r_cfg_tps        <= i_cfg_data[7:0];
                CFG_BLINK_TICKS: r_cfg_blink      <= i_cfg_data[7:0];
                CFG_MIN_TEMP:    r_cfg_min_temp   <= i_cfg_data;
                CFG_BROIL_TEMP:  r_cfg_broil_temp <= i_cfg_data;
                CFG_BAKE_TEMP:   r_cfg_bake_temp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------------
    t_phase               r_phase, n_phase;
    t_mode                r_mode, n_mode;
    logic                 r_target, n_target;
    logic [8:0]           r_total, n_total;
    logic [8:0]           r_secs, n_secs;
    logic [10:0]          r_temp, n_temp;
    logic [TICK_BITS-1:0] r_free, n_free;
    logic [TICK_BITS-1:0] r_press, n_press;
    logic [7:0]           r_sub, n_sub;
    logic [LED_COUNT-1:0] r_led, n_led;
    logic [3:0]           r_led_step, n_led_step;
    logic [7:0]           r_blink_cnt, n_blink_cnt;
    logic                 r_blink_phase, n_blink_phase;
    logic                 r_inverted, n_inverted;
    logic                 r_knob_pend, n_knob_pend;
    logic [KNOB_BITS-1:0] r_knob_latch, n_knob_latch;

    // Result register.
    logic                 r_out_valid;
    t_phase               r_o_state;
    t_mode                r_o_mode;
    logic                 r_o_target;
    logic [8:0]           r_o_total;
    logic [8:0]           r_o_secs;
    logic [10:0]          r_o_temp;
    logic [LED_COUNT-1:0] r_o_led;
    logic                 r_o_heater;
    logic                 r_o_inverted;
    logic                 r_o_refresh;

    logic in_ready;
    logic in_accept;

    // A beat enters when the result register is free or being emptied.
    assign in_ready  = !r_out_valid || o_out.ready;
    assign in_accept = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // ------------------------------------------------------------------------
    // Countdown helpers, computed from the registered state. Within a
    // counting phase the total time and remaining seconds are unchanged
    // before the tick is handled, so these can be taken from the registers.
    // ------------------------------------------------------------------------
    // The share of the total time per LED is taken by multiplying with the
    // rounded-up reciprocal of LED_COUNT over 2^14, which is exact for every
    // nine-bit total.
    localparam int          RECIP_SHIFT = 14;
    localparam int unsigned LED_RECIP   = ((1 << RECIP_SHIFT) + LED_COUNT - 1) / LED_COUNT;

    logic [8:0]         secs_dec;
    logic [22:0]        led_quot;
    logic [8:0]         led_chunk;
    logic [12:0]        led_prod;
    logic signed [13:0] led_edge;
    logic               led_advance;
    logic [7:0]         sub_inc;
    logic [7:0]         blink_inc;
    logic [TICK_BITS-1:0] held_ticks;
    logic [7:0]         knob_scaled;

    assign secs_dec  = r_secs - 9'd1;
    assign led_quot  = {14'd0, r_total} * {9'd0, 14'(LED_RECIP)};
    assign led_chunk = led_quot[22:RECIP_SHIFT];
    assign led_prod  = {9'd0, r_led_step} * {4'd0, led_chunk};
    // The edge may fall below zero once the step runs past the last LED.
    assign led_edge  = $signed({5'd0, r_total}) - $signed({1'b0, led_prod});
    assign led_advance = led_edge >= $signed({5'd0, secs_dec});
    assign sub_inc   = r_sub + 8'd1;
    assign blink_inc = r_blink_cnt + 8'd1;

    always_comb begin
        logic press_long;
        logic sub_done;

        n_phase       = r_phase;
        n_mode        = r_mode;
        n_target      = r_target;
        n_total       = r_total;
        n_secs        = r_secs;
        n_temp        = r_temp;
        n_free        = r_free;
        n_press       = r_press;
        n_sub         = r_sub;
        n_led         = r_led;
        n_led_step    = r_led_step;
        n_blink_cnt   = r_blink_cnt;
        n_blink_phase = r_blink_phase;
        n_inverted    = r_inverted;
        n_knob_pend   = r_knob_pend;
        n_knob_latch  = r_knob_latch;

        // The free-running tick count moves first, then the knob is latched.
        if (i_in.tick) begin
            n_free = r_free + TICK_BITS'(1);
        end
        if (i_in.knob_valid) begin
            n_knob_latch = i_in.knob_value;
            n_knob_pend  = 1'b1;
        end

        held_ticks  = n_free - r_press;
        press_long  = held_ticks >= TICK_BITS'(r_cfg_long);
        knob_scaled = n_knob_latch[KNOB_BITS-1 -: 8];
        sub_done    = sub_inc >= r_cfg_tps;

        unique case (r_phase) inside
            PH_SETUP: begin
                if (n_knob_pend) begin
                    n_knob_pend = 1'b0;
                    if (r_mode == MODE_BAKE && r_target == TGT_TEMP) begin
                        n_temp = 11'(knob_scaled) + 11'(r_cfg_min_temp);
                    end else begin
                        n_total = 9'(knob_scaled) + 9'd1;
                    end
                end
                if (i_in.select_press) begin
                    n_press = n_free;
                    n_phase = PH_SELECT;
                end
                if (i_in.start_press) begin
                    n_secs     = n_total;
                    n_led      = '1;
                    n_led_step = 4'd1;
                    n_sub      = 8'd0;
                    n_phase    = PH_COOK;
                end
            end
            PH_SELECT: begin
                if (i_in.select_release) begin
                    if (!press_long) begin
                        if (r_mode == MODE_BAKE) begin
                            n_mode = MODE_TOAST;
                        end else if (r_mode == MODE_TOAST) begin
                            n_mode = MODE_BROIL;
                            n_temp = 11'(r_cfg_broil_temp);
                        end else begin
                            n_mode   = MODE_BAKE;
                            n_temp   = 11'(r_cfg_bake_temp);
                            n_target = TGT_TIME;
                        end
                    end else begin
                        n_target = !r_target;
                    end
                    n_phase = PH_SETUP;
                end
            end
            PH_COOK, PH_RESET: begin
                if (i_in.tick) begin
                    n_sub = sub_inc;
                    if (r_secs == 9'd0) begin
                        n_led         = '0;
                        n_blink_cnt   = 8'd0;
                        n_blink_phase = 1'b1;
                        n_phase       = PH_TIMEUP;
                    end else if (sub_done) begin
                        n_secs = secs_dec;
                        if (led_advance) begin
                            n_led      = {r_led[LED_COUNT-2:0], 1'b0};
                            n_led_step = r_led_step + 4'd1;
                        end
                        n_sub = 8'd0;
                    end
                end
                if (r_phase == PH_COOK) begin
                    if (i_in.start_press) begin
                        n_press = n_free;
                        n_phase = PH_RESET;
                    end
                end else if (i_in.start_release) begin
                    // A short press resumes; a long one aborts the cook.
                    if (!press_long) begin
                        n_phase = PH_COOK;
                    end else begin
                        n_led   = '0;
                        n_phase = PH_SETUP;
                    end
                end
            end
            PH_TIMEUP: begin
                if (i_in.tick) begin
                    n_blink_cnt = blink_inc;
                    if (blink_inc >= r_cfg_blink) begin
                        n_inverted    = r_blink_phase;
                        n_blink_phase = !r_blink_phase;
                        n_blink_cnt   = 8'd0;
                    end
                end
                if (i_in.start_release) begin
                    n_inverted = 1'b0;
                    n_phase    = PH_SETUP;
                end
            end
            default: begin
                n_phase = PH_SETUP;
            end
        endcase
    end

    logic refresh_next;
    assign refresh_next = (n_phase != r_phase) || (n_mode != r_mode) ||
                          (n_target != r_target) || (n_total != r_total) ||
                          (n_secs != r_secs) || (n_temp != r_temp) ||
                          (n_inverted != r_inverted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SETUP;
            r_mode        <= MODE_BAKE;
            r_target      <= TGT_TIME;
            r_total       <= 9'd1;
            r_secs        <= 9'd0;
            r_temp        <= 11'd350;
            r_free        <= '0;
            r_press       <= '0;
            r_sub         <= 8'd0;
            r_led         <= '0;
            r_led_step    <= 4'd1;
            r_blink_cnt   <= 8'd0;
            r_blink_phase <= 1'b1;
            r_inverted    <= 1'b0;
            r_knob_pend   <= 1'b0;
            r_knob_latch  <= '0;
        end else if (in_accept) begin
            r_phase       <= n_phase;
            r_mode        <= n_mode;
            r_target      <= n_target;
            r_total       <= n_total;
            r_secs        <= n_secs;
            r_temp        <= n_temp;
            r_free        <= n_free;
            r_press       <= n_press;
            r_sub         <= n_sub;
            r_led         <= n_led;
            r_led_step    <= n_led_step;
            r_blink_cnt   <= n_blink_cnt;
            r_blink_phase <= n_blink_phase;
            r_inverted    <= n_inverted;
            r_knob_pend   <= n_knob_pend;
            r_knob_latch  <= n_knob_latch;
        end
    end

    // Result register: valid is control, the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_o_state    <= n_phase;
            r_o_mode     <= n_mode;
            r_o_target   <= n_target;
            r_o_total    <= n_total;
            r_o_secs     <= n_secs;
            r_o_temp     <= n_temp;
            r_o_led      <= n_led;
            r_o_heater   <= (n_phase == PH_COOK) || (n_phase == PH_RESET);
            r_o_inverted <= n_inverted;
            r_o_refresh  <= refresh_next;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.oven_state       = r_o_state;
    assign o_out.cook_mode        = r_o_mode;
    assign o_out.adjust_target    = r_o_target;
    assign o_out.set_time         = r_o_total;
    assign o_out.remaining_time   = r_o_secs;
    assign o_out.set_temperature  = r_o_temp;
    assign o_out.led_bar          = r_o_led;
    assign o_out.heater_on        = r_o_heater;
    assign o_out.display_inverted = r_o_inverted;
    assign o_out.refresh          = r_o_refresh;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted beat produced no result beat");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while result register is blocked");

    a_timeup_leds_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TIMEUP) |-> (r_led == '0))
        else $error("LED bar lit in time-up phase");

    a_setup_consumes_knob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_SETUP) |=> !r_knob_pend)
        else $error("knob value left pending after a setup beat");

    a_heater_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (o_out.heater_on ==
            (o_out.oven_state == PH_COOK || o_out.oven_state == PH_RESET)))
        else $error("heater output disagrees with shown phase");

endmodule

>>> test/oven_cook_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oven cook controller testbench
// Sends event beats with random gaps and takes result beats with random
// stalls. A beat-exact software copy of the controller predicts every
// result beat, and each result beat is checked field by field.
// ----------------------------------------------------------------------------
module oven_cook_controller_top_test;
    import ocook_pkg::*;

    // Watchdog on cycles without any accepted beat, and stimulus sizing.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 180;
    localparam int RANDOM_PHASES  = 8;

    // One event beat as the stimulus queue holds it.
    typedef struct packed {
        logic                     tick;
        logic                     knob_valid;
        logic [KNOB_BITS_DEF-1:0] knob_value;
        logic                     sel_dn;
        logic                     sel_up;
        logic                     st_dn;
        logic                     st_up;
    } ctl_beat_t;

    // One result beat: what the panel should show after an event beat.
    typedef struct packed {
        t_phase                   oven_state;
        t_mode                    cook_mode;
        logic                     adjust_target;
        logic [8:0]               set_time;
        logic [8:0]               remaining_time;
        logic [10:0]              set_temperature;
        logic [LED_COUNT_DEF-1:0] led_bar;
        logic                     heater_on;
        logic                     display_inverted;
        logic                     refresh;
    } panel_t;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    ocook_in_if  #(.KNOB_BITS(KNOB_BITS_DEF)) ev_if ();
    ocook_out_if #(.LED_COUNT(LED_COUNT_DEF)) pn_if ();

    oven_cook_controller_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (ev_if),
        .o_out       (pn_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Beats waiting to be sent, and the panels we expect back, oldest first.
    ctl_beat_t beat_q[$];
    panel_t    panel_q[$];
    ctl_beat_t cur_beat;
    int        queued;
    int        fail_count;

    // Sender pacing: a burst of back-to-back beats, then a gap. While
    // hold_feed is high the sender presents nothing new.
    int        burst_left;
    int        gap_left;
    logic      hold_feed;

    // Receiver pacing and the watchdog.
    int        pat_mode;
    int        pat_left;
    logic [7:0] cyc_count;
    int        idle_cycles;

    // Our copy of the controller configuration.
    logic [7:0] cfg_long;
    logic [7:0] cfg_tps;
    logic [7:0] cfg_blink;
    logic [9:0] cfg_tmin;
    logic [9:0] cfg_tbroil;
    logic [9:0] cfg_tbake;

    // Our copy of the controller state.
    t_phase     st_phase;
    t_mode      st_mode;
    logic       st_target;
    logic [8:0] st_total;
    logic [8:0] st_left;
    logic [10:0] st_temp;
    logic [15:0] st_ticks;
    logic [15:0] st_stamp;
    logic [7:0] st_subsec;
    logic [LED_COUNT_DEF-1:0] st_leds;
    logic [3:0] st_ledstep;
    logic [7:0] st_blink_cnt;
    logic       st_blink_ph;
    logic       st_inverted;
    logic       st_knob_pend;
    logic [KNOB_BITS_DEF-1:0] st_knob_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A press counts as long once the free tick count has moved on by at
    // least the long-press setting since the button went down; the tick
    // counter wraps, so the difference is taken at its own width.
    function automatic logic long_hold();
        logic [15:0] held;
        held = st_ticks - st_stamp;
        return held >= 16'(cfg_long);
    endfunction

    // The bar loses one LED each time another eighth of the total time has
    // gone. Signed arithmetic matters: the threshold goes negative once the
    // step count runs past the number of LEDs.
    task automatic shift_leds();
        int chunk;
        int edge_sec;
        chunk    = int'(st_total) / LED_COUNT_DEF;
        edge_sec = int'(st_total) - int'(st_ledstep) * chunk;
        if (edge_sec >= int'(st_left)) begin
            st_leds    = st_leds << 1;
            st_ledstep = st_ledstep + 4'd1;
        end
    endtask

    // One tick while cooking or while an abort press is pending.
    task automatic count_second();
        st_subsec = st_subsec + 8'd1;
        if (st_left == 9'd0) begin
            st_leds      = '0;
            st_blink_cnt = 8'd0;
            st_blink_ph  = 1'b1;
            st_phase     = PH_TIMEUP;
        end else if (st_subsec >= cfg_tps) begin
            st_left   = st_left - 9'd1;
            shift_leds();
            st_subsec = 8'd0;
        end
    endtask

    // Applies one accepted event beat and works out the panel it produces.
    task automatic cook_step(input ctl_beat_t b, output panel_t p);
        t_phase      ph0;
        t_mode       md0;
        logic        tg0;
        logic [8:0]  tot0;
        logic [8:0]  left0;
        logic [10:0] temp0;
        logic        inv0;
        logic [7:0]  scaled;
        ph0   = st_phase;
        md0   = st_mode;
        tg0   = st_target;
        tot0  = st_total;
        left0 = st_left;
        temp0 = st_temp;
        inv0  = st_inverted;

        if (b.tick) begin
            st_ticks = st_ticks + 16'd1;
        end
        if (b.knob_valid) begin
            st_knob_hold = b.knob_value;
            st_knob_pend = 1'b1;
        end

        case (st_phase)
            PH_SETUP: begin
                // A knob reading held from another phase lands here too.
                if (st_knob_pend) begin
                    st_knob_pend = 1'b0;
                    scaled = 8'(st_knob_hold >> (KNOB_BITS_DEF - 8));
                    if (st_mode == MODE_BAKE && st_target == TGT_TEMP) begin
                        st_temp = 11'(scaled) + 11'(cfg_tmin);
                    end else begin
                        st_total = 9'(scaled) + 9'd1;
                    end
                end
                if (b.sel_dn) begin
                    st_stamp = st_ticks;
                    st_phase = PH_SELECT;
                end
                // Start wins over a selector press in the same beat.
                if (b.st_dn) begin
                    st_left    = st_total;
                    st_leds    = '1;
                    st_ledstep = 4'd1;
                    st_subsec  = 8'd0;
                    st_phase   = PH_COOK;
                end
            end
            PH_SELECT: begin
                if (b.sel_up) begin
                    if (!long_hold()) begin
                        if (st_mode == MODE_BAKE) begin
                            st_mode = MODE_TOAST;
                        end else if (st_mode == MODE_TOAST) begin
                            st_mode = MODE_BROIL;
                            st_temp = 11'(cfg_tbroil);
                        end else begin
                            st_mode   = MODE_BAKE;
                            st_temp   = 11'(cfg_tbake);
                            st_target = TGT_TIME;
                        end
                    end else begin
                        st_target = ~st_target;
                    end
                    st_phase = PH_SETUP;
                end
            end
            PH_COOK: begin
                if (b.tick) begin
                    count_second();
                end
                if (b.st_dn) begin
                    st_stamp = st_ticks;
                    st_phase = PH_RESET;
                end
            end
            PH_RESET: begin
                if (b.tick) begin
                    count_second();
                end
                if (b.st_up) begin
                    if (!long_hold()) begin
                        st_phase = PH_COOK;
                    end else begin
                        st_leds  = '0;
                        st_phase = PH_SETUP;
                    end
                end
            end
            PH_TIMEUP: begin
                if (b.tick) begin
                    st_blink_cnt = st_blink_cnt + 8'd1;
                    if (st_blink_cnt >= cfg_blink) begin
                        st_inverted  = st_blink_ph;
                        st_blink_ph  = ~st_blink_ph;
                        st_blink_cnt = 8'd0;
                    end
                end
                if (b.st_up) begin
                    st_inverted = 1'b0;
                    st_phase    = PH_SETUP;
                end
            end
            default: begin
                st_phase = PH_SETUP;
            end
        endcase

        p.oven_state       = st_phase;
        p.cook_mode        = st_mode;
        p.adjust_target    = st_target;
        p.set_time         = st_total;
        p.remaining_time   = st_left;
        p.set_temperature  = st_temp;
        p.led_bar          = st_leds;
        p.heater_on        = (st_phase == PH_COOK) || (st_phase == PH_RESET);
        p.display_inverted = st_inverted;
        p.refresh          = (ph0 != st_phase) || (md0 != st_mode) || (tg0 != st_target) ||
                             (tot0 != st_total) || (left0 != st_left) ||
                             (temp0 != st_temp) || (inv0 != st_inverted);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_event(input int unsigned tick, input int unsigned kv,
                                        input int unsigned kval, input int unsigned sd,
                                        input int unsigned su, input int unsigned td,
                                        input int unsigned tu);
        ctl_beat_t b;
        b.tick       = 1'(tick);
        b.knob_valid = 1'(kv);
        b.knob_value = KNOB_BITS_DEF'(kval);
        b.sel_dn     = 1'(sd);
        b.sel_up     = 1'(su);
        b.st_dn      = 1'(td);
        b.st_up      = 1'(tu);
        beat_q.push_back(b);
        queued++;
    endfunction

    // Mostly small readings, so that cook times stay short enough for the
    // countdown to run out; now and then anything the converter can give.
    function automatic int unsigned knob_pick();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1023);
        end
        return $urandom_range(0, 47);
    endfunction

    // Queues one user interaction with random content. Most are the
    // well-formed sequences a real user would produce; the rest is noise.
    task automatic queue_session();
        int kind;
        int n;
        int r;
        int cook_cap;
        kind = $urandom_range(0, 9);
        case (kind) inside
            0, 1: begin
                // Turning the knob.
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    queue_event($urandom_range(0, 1), 1, knob_pick(), 0, 0, 0, 0);
                end
            end
            2, 3: begin
                // Selector press held for a few ticks around the long limit.
                queue_event($urandom_range(0, 1), 0, 0, 1, 0, 0, 0);
                n = $urandom_range(0, int'(cfg_long) + 2);
                for (int k = 0; k < n; k++) begin
                    queue_event(1, ($urandom_range(0, 7) == 0), knob_pick(), 0, 0, 0, 0);
                end
                queue_event(0, 0, 0, 0, 1, 0, 0);
            end
            4, 5, 6: begin
                // Start and let it cook, with the odd start press or
                // release thrown in, then release start.
                queue_event(0, 0, 0, 0, 0, 1, 0);
                cook_cap = int'(cfg_tps) * 10 + 4;
                if (cook_cap > 300) begin
                    cook_cap = 300;
                end
                n = $urandom_range(1, cook_cap);
                for (int k = 0; k < n; k++) begin
                    r = $urandom_range(0, 29);
                    if (r == 0) begin
                        queue_event(1, 0, 0, 0, 0, 1, 0);
                    end else if (r == 1) begin
                        queue_event(0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        queue_event(($urandom_range(0, 7) != 0), ($urandom_range(0, 15) == 0),
                                    knob_pick(), 0, 0, 0, 0);
                    end
                end
                queue_event(0, 0, 0, 0, 0, 0, 1);
            end
            7: begin
                // Start, then a start press of random length: a long one
                // aborts, a short one resumes cooking.
                queue_event(0, 0, 0, 0, 0, 1, 0);
                queue_event($urandom_range(0, 1), 0, 0, 0, 0, 1, 0);
                n = $urandom_range(0, int'(cfg_long) + 2);
                for (int k = 0; k < n; k++) begin
                    queue_event(1, 0, 0, 0, 0, 0, 0);
                end
                queue_event(0, 0, 0, 0, 0, 0, 1);
            end
            8: begin
                // Noise: every field random.
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    queue_event($urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1023), $urandom_range(0, 1),
                                $urandom_range(0, 1), $urandom_range(0, 1),
                                $urandom_range(0, 1));
                end
            end
            default: begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) begin
                    queue_event($urandom_range(0, 1), 0, 0, 0, 0, 0, 0);
                end
            end
        endcase
    endtask

    // Sets up one register write for the next rising edge and updates our
    // copy of the register straight away; the block is idle meanwhile.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= t_cfg_data'(data);
        case (idx)
            CFG_LONG_PRESS:  cfg_long   = 8'(data);
            CFG_TICKS_SEC:   cfg_tps    = 8'(data);
            CFG_BLINK_TICKS: cfg_blink  = 8'(data);
            CFG_MIN_TEMP:    cfg_tmin   = 10'(data);
            CFG_BROIL_TEMP:  cfg_tbroil = 10'(data);
            CFG_BAKE_TEMP:   cfg_tbake  = 10'(data);
            default: ;
        endcase
    endtask

    // Back-to-back writes of all six registers; the enable drops after the
    // last one has been taken.
    task automatic program_regs(input int unsigned lp, input int unsigned tps,
                                input int unsigned blink, input int unsigned tmin,
                                input int unsigned tbroil, input int unsigned tbake);
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_TICKS_SEC, tps);
        write_reg(CFG_BLINK_TICKS, blink);
        write_reg(CFG_MIN_TEMP, tmin);
        write_reg(CFG_BROIL_TEMP, tbroil);
        write_reg(CFG_BAKE_TEMP, tbake);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every queued beat has gone in and every expected panel
    // has come back, then lets the result register settle.
    task automatic wait_drained();
        while (beat_q.size() != 0 || ev_if.valid || panel_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents beats from the stimulus queue in bursts and predicts
    // the panel for each beat on the edge at which it is accepted. A beat
    // that is not taken stays on the bus unchanged.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        panel_t want;
        if (!i_rst_n) begin
            ev_if.valid <= 1'b0;
        end else begin
            if (ev_if.valid && ev_if.ready) begin
                cook_step(cur_beat, want);
                panel_q.push_back(want);
            end
            if (!ev_if.valid || ev_if.ready) begin
                if (gap_left != 0 || hold_feed || beat_q.size() == 0) begin
                    ev_if.valid <= 1'b0;
                    if (gap_left != 0) begin
                        gap_left <= gap_left - 1;
                    end
                end else begin
                    cur_beat = beat_q.pop_front();
                    ev_if.valid          <= 1'b1;
                    ev_if.tick           <= cur_beat.tick;
                    ev_if.knob_valid     <= cur_beat.knob_valid;
                    ev_if.knob_value     <= cur_beat.knob_value;
                    ev_if.select_press   <= cur_beat.sel_dn;
                    ev_if.select_release <= cur_beat.sel_up;
                    ev_if.start_press    <= cur_beat.st_dn;
                    ev_if.start_release  <= cur_beat.st_up;
                    // A third of the bursts run straight into the next one,
                    // so there are long stretches with no idling at all.
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result beat against the oldest expected
    // panel, paces ready on a pattern of its own and runs the watchdog.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        panel_t want;
        if (!i_rst_n) begin
            pn_if.ready <= 1'b0;
            idle_cycles <= 0;
        end else begin
            if (pn_if.valid && pn_if.ready) begin
                if (panel_q.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected, state %0d",
                             $time, pn_if.oven_state);
                    fail_count++;
                end else begin
                    want = panel_q.pop_front();
                    check_field("oven_state", 32'(want.oven_state), 32'(pn_if.oven_state));
                    check_field("cook_mode", 32'(want.cook_mode), 32'(pn_if.cook_mode));
                    check_field("adjust_target", 32'(want.adjust_target),
                                32'(pn_if.adjust_target));
                    check_field("set_time", 32'(want.set_time), 32'(pn_if.set_time));
                    check_field("remaining_time", 32'(want.remaining_time),
                                32'(pn_if.remaining_time));
                    check_field("set_temperature", 32'(want.set_temperature),
                                32'(pn_if.set_temperature));
                    check_field("led_bar", 32'(want.led_bar), 32'(pn_if.led_bar));
                    check_field("heater_on", 32'(want.heater_on), 32'(pn_if.heater_on));
                    check_field("display_inverted", 32'(want.display_inverted),
                                32'(pn_if.display_inverted));
                    check_field("refresh", 32'(want.refresh), 32'(pn_if.refresh));
                end
            end

            // The stall pattern is picked anew each time its run ends: always ready,
            // light random stalls, a fixed on-off rhythm from a counter bit, or heavy
            // stalls that back the result register up.
            if (pat_left == 0) begin
                pat_mode <= $urandom_range(0, 3);
                pat_left <= $urandom_range(50, 300);
            end else begin
                pat_left <= pat_left - 1;
            end
            case (pat_mode)
                0:       pn_if.ready <= 1'b1;
                1:       pn_if.ready <= ($urandom_range(0, 3) != 0);
                2:       pn_if.ready <= cyc_count[2];
                default: pn_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
            cyc_count <= cyc_count + 8'd1;

            if ((ev_if.valid && ev_if.ready) || (pn_if.valid && pn_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run: reset, a directed part under the reset settings,
    // then random phases, each under its own register settings.
    // ------------------------------------------------------------------------
    initial begin
        int base;

        // Every input of the block is known from time zero.
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = CFG_LONG_PRESS;
        i_cfg_data           = '0;
        ev_if.valid          = 1'b0;
        ev_if.tick           = 1'b0;
        ev_if.knob_valid     = 1'b0;
        ev_if.knob_value     = '0;
        ev_if.select_press   = 1'b0;
        ev_if.select_release = 1'b0;
        ev_if.start_press    = 1'b0;
        ev_if.start_release  = 1'b0;
        pn_if.ready          = 1'b0;
        hold_feed            = 1'b0;
        burst_left           = 1;
        gap_left             = 0;
        pat_mode             = 0;
        pat_left             = 0;
        cyc_count            = 8'd0;
        idle_cycles          = 0;
        fail_count           = 0;
        queued               = 0;

        // Registers and state as the block comes out of reset.
        cfg_long     = LONG_PRESS_RST;
        cfg_tps      = TICKS_SEC_RST;
        cfg_blink    = BLINK_TICKS_RST;
        cfg_tmin     = MIN_TEMP_RST;
        cfg_tbroil   = BROIL_TEMP_RST;
        cfg_tbake    = BAKE_TEMP_RST;
        st_phase     = PH_SETUP;
        st_mode      = MODE_BAKE;
        st_target    = TGT_TIME;
        st_total     = 9'd1;
        st_left      = 9'd0;
        st_temp      = 11'd350;
        st_ticks     = 16'd0;
        st_stamp     = 16'd0;
        st_subsec    = 8'd0;
        st_leds      = '0;
        st_ledstep   = 4'd1;
        st_blink_cnt = 8'd0;
        st_blink_ph  = 1'b1;
        st_inverted  = 1'b0;
        st_knob_pend = 1'b0;
        st_knob_hold = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset settings. Knob extremes set the time to one and
        // then 256 seconds; the tick in setup is dropped.
        queue_event(1, 1, 0, 0, 0, 0, 0);
        queue_event(0, 1, 1023, 0, 0, 0, 0);
        // Long selector press flips the target to temperature. The knob
        // turned meanwhile is held and lands on the first beat back in
        // setup.
        queue_event(0, 0, 0, 1, 0, 0, 0);
        for (int k = 0; k < 5; k++) begin
            queue_event(1, (k == 2), 100, 0, 0, 0, 0);
        end
        queue_event(0, 0, 0, 0, 1, 0, 0);
        queue_event(0, 0, 0, 0, 0, 0, 0);
        queue_event(0, 1, 1023, 0, 0, 0, 0);
        // Three short presses: toast, broil, back to bake.
        for (int k = 0; k < 3; k++) begin
            queue_event(0, 0, 0, 1, 0, 0, 0);
            queue_event(0, 0, 0, 0, 1, 0, 0);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: program_regs(1, 1, 1, 0, 0, 0);
                2: program_regs(255, 255, 255, 1023, 1023, 1023);
                default: program_regs($urandom_range(1, 10), $urandom_range(1, 6),
                                      $urandom_range(1, 8), $urandom_range(0, 1023),
                                      $urandom_range(0, 1023), $urandom_range(0, 1023));
            endcase

            if (ph == 1) begin
                // Directed, every counter at one tick. Knob, selector and
                // start in one beat: start wins.
                queue_event(0, 1, 0, 0, 0, 0, 0);
                queue_event(0, 1, 4, 1, 0, 1, 0);
                // A knob reading while cooking is held for later.
                queue_event(1, 1, 160, 0, 0, 0, 0);
                // Short start press resumes cooking.
                queue_event(0, 0, 0, 0, 0, 1, 0);
                queue_event(0, 0, 0, 0, 0, 0, 1);
                // Count down to zero, into time up, and blink a few times.
                for (int k = 0; k < 5; k++) begin
                    queue_event(1, 0, 0, 0, 0, 0, 0);
                end
                queue_event(0, 0, 0, 0, 0, 0, 1);
                // The held reading applies now; then a long start press
                // aborts, the tick in the release beat making it long.
                queue_event(0, 0, 0, 0, 0, 0, 0);
                queue_event(0, 0, 0, 0, 0, 1, 0);
                queue_event(0, 0, 0, 0, 0, 1, 0);
                queue_event(1, 0, 0, 0, 0, 0, 1);
                // Every event at once.
                queue_event(1, 1, 1023, 1, 1, 1, 1);
            end

            base = queued;
            while (queued - base < PHASE_BEATS) begin
                queue_session();
            end

            // Now and then the sender stops mid-phase until every expected
            // panel is back, then carries on.
            if (ph % 3 == 0) begin
                while (beat_q.size() > PHASE_BEATS / 2) begin
                    @(negedge i_clk);
                end
                hold_feed = 1'b1;
                while (ev_if.valid || panel_q.size() != 0) begin
                    @(negedge i_clk);
                end
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
                hold_feed = 1'b0;
            end

            wait_drained();
        end

        repeat (4) @(negedge i_clk);
        if (panel_q.size() != 0) begin
            $display("%0t ns: %0d expected panels never arrived", $time, panel_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
